// ===== design/lwsmc_pkg.sv =====
package lwsmc_pkg;

    // lattice geometry and species count
    localparam int SIDE    = 32;
    localparam int SPECIES = 4;

    localparam int COORD_W = $clog2(SIDE);
    localparam int ADDR_W  = 3 * COORD_W;
    localparam int CELLS   = SIDE * SIDE * SIDE;

    localparam int CODE_W  = 4;
    localparam int PROB_W  = 17;
    localparam int RAND_W  = 16;
    localparam int CFG_IDX_W = 3;

    // cell codes
    localparam logic [CODE_W-1:0] CODE_EMPTY      = '0;
    localparam logic [CODE_W-1:0] CODE_NUT_FIRST  = CODE_W'(1);
    localparam logic [CODE_W-1:0] CODE_NUT_LAST   = CODE_W'(SPECIES);
    localparam logic [CODE_W-1:0] CODE_SOIL       = CODE_W'(SPECIES + 1);
    localparam logic [CODE_W-1:0] CODE_WORM_FIRST = CODE_W'(SPECIES + 2);
    localparam logic [CODE_W-1:0] CODE_WORM_LAST  = CODE_W'(2 * SPECIES + 1);

    // operations
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // direction codes beyond the last valid one leave the lattice alone
    localparam logic [2:0] DIR_LIMIT = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RULE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_PROB = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEATH_PROB = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIRTH_PROB = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPOSIT_PROB = 3'd4;

    // register reset values
    localparam logic [PROB_W-1:0] FILL_PROB_RST    = PROB_W'(32768);
    localparam logic [PROB_W-1:0] DEATH_PROB_RST   = PROB_W'(1311);
    localparam logic [PROB_W-1:0] BIRTH_PROB_RST   = PROB_W'(65536);
    localparam logic [PROB_W-1:0] DEPOSIT_PROB_RST = PROB_W'(65536);

    typedef struct packed {
        logic              operation;
        logic [4:0]        site_x;
        logic [4:0]        site_y;
        logic [4:0]        site_z;
        logic [2:0]        direction;
        logic [RAND_W-1:0] first_random;
        logic [RAND_W-1:0] second_random;
        logic [CODE_W-1:0] load_value;
    } step_req_t;

    typedef struct packed {
        logic [CODE_W-1:0] site_before;
        logic [CODE_W-1:0] site_after;
        logic [CODE_W-1:0] neighbour_before;
        logic [CODE_W-1:0] neighbour_after;
    } step_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WRITE
    } state_t;

    // neighbour coordinate with periodic wrap
    function automatic logic [COORD_W-1:0] wrap_step(input logic [COORD_W-1:0] c,
                                                     input logic plus);
        logic [COORD_W-1:0] r;
        if (plus)
        begin
            r = (c == COORD_W'(SIDE - 1)) ? '0 : c + COORD_W'(1);
        end
        else
        begin
            r = (c == '0) ? COORD_W'(SIDE - 1) : c - COORD_W'(1);
        end
        return r;
    endfunction

    // reduce a five-bit coordinate into the lattice
    function automatic logic [COORD_W-1:0] fold_coord(input logic [4:0] c);
        logic [5:0] t;
        t = {1'b0, c};
        if (t >= 6'(SIDE))
        begin
            t = t - 6'(SIDE);
        end
        return COORD_W'(t);
    endfunction

    function automatic logic is_nutrient(input logic [CODE_W-1:0] v);
        return (v >= CODE_NUT_FIRST) && (v <= CODE_NUT_LAST);
    endfunction

    function automatic logic is_worm(input logic [CODE_W-1:0] v);
        return (v >= CODE_WORM_FIRST) && (v <= CODE_WORM_LAST);
    endfunction

endpackage

// ===== design/lattice_worm_soil_monte_carlo_step_core.sv =====
// Soil and worm lattice update engine.
// Requests arrive on in_valid / in_stall / in_data. Each request is either a
// load (writes one cell) or a step (one stochastic update of a site and one
// neighbour). Every request gives exactly one result on out_valid /
// out_stall / out_data: the site and neighbour codes before and after.
// A request is taken when in_valid is high and in_stall is low.
// The two cells are read from the dual-read lattice memory at the
// accepting edge; the next cycle evaluates and writes the neighbour, the
// one after writes the site and loads the output register. A new request
// is taken only once the previous one is done, as in_stall stays high
// outside the idle state; the single lattice write port serves both writes.
// While a result waits in the output register under out_stall, the next
// request is still accepted and worked on; it holds in its final cycle
// until the output register frees.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and belong to idle periods. Reset clears control state and restores the
// register defaults; the lattice content is undefined until loaded.
module lattice_worm_soil_monte_carlo_step_core
    import lwsmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  step_req_t            in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output step_res_t            out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PROB_W-1:0]    cfg_data
);

    // lattice memory
    logic [CODE_W-1:0] lattice_mem [CELLS];

    state_t            state_reg, state_next;
    step_req_t         req_reg;
    logic [ADDR_W-1:0] site_addr_reg, nbr_addr_reg;
    logic              nbr_used_reg;
    logic [CODE_W-1:0] site_rd_reg, nbr_rd_reg;
    step_res_t         res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    step_res_t         out_data_reg, out_data_next;

    logic              rule_mode_reg;
    logic [PROB_W-1:0] fill_prob_reg, death_prob_reg, birth_prob_reg, deposit_prob_reg;

    logic              accept;
    logic [COORD_W-1:0] sx, sy, sz, nx, ny, nz;
    logic [ADDR_W-1:0] site_addr, nbr_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CODE_W-1:0] mem_wdata;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // site and neighbour addresses
    always_comb
    begin
        sx = fold_coord(in_data.site_x);
        sy = fold_coord(in_data.site_y);
        sz = fold_coord(in_data.site_z);
        nx = sx;
        ny = sy;
        nz = sz;
        case (in_data.direction[2:1])
            2'd0: nx = wrap_step(sx, in_data.direction[0]);
            2'd1: ny = wrap_step(sy, in_data.direction[0]);
            2'd2: nz = wrap_step(sz, in_data.direction[0]);
            default: ;
        endcase
        site_addr = {sx, sy, sz};
        nbr_addr  = {nx, ny, nz};
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_mode_reg    <= 1'b0;
            fill_prob_reg    <= FILL_PROB_RST;
            death_prob_reg   <= DEATH_PROB_RST;
            birth_prob_reg   <= BIRTH_PROB_RST;
            deposit_prob_reg <= DEPOSIT_PROB_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RULE_MODE:    rule_mode_reg    <= cfg_data[0];
                REG_FILL_PROB:    fill_prob_reg    <= cfg_data;
                REG_DEATH_PROB:   death_prob_reg   <= cfg_data;
                REG_BIRTH_PROB:   birth_prob_reg   <= cfg_data;
                REG_DEPOSIT_PROB: deposit_prob_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // memory write port and registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lattice_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            site_rd_reg <= lattice_mem[site_addr];
            nbr_rd_reg  <= lattice_mem[nbr_addr];
        end
    end

    // request capture and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg       <= in_data;
            site_addr_reg <= site_addr;
            nbr_addr_reg  <= nbr_addr;
            nbr_used_reg  <= (in_data.operation == OP_STEP) && (in_data.direction < DIR_LIMIT);
        end
        if (state_reg == ST_EVAL)
        begin
            res_reg <= res_next;
        end
        out_data_reg <= out_data_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // update rule evaluation
    always_comb
    begin
        logic [CODE_W-1:0] s0, n0, s1, n1, spc, prey;
        logic              edible;
        s0 = site_rd_reg;
        n0 = nbr_rd_reg;
        s1 = s0;
        n1 = n0;
        spc = s0 - CODE_SOIL;
        prey = (spc == CODE_NUT_LAST) ? CODE_NUT_FIRST : spc + CODE_W'(1);
        if (rule_mode_reg)
        begin
            edible = is_nutrient(n0) && (n0 != spc);
        end
        else
        begin
            edible = (n0 == prey);
        end
        if (req_reg.operation == OP_LOAD)
        begin
            s1 = req_reg.load_value;
        end
        else if (nbr_used_reg)
        begin
            if ((s0 == CODE_EMPTY) || is_nutrient(s0))
            begin
                if ((n0 == CODE_SOIL) && ({1'b0, req_reg.first_random} < fill_prob_reg))
                begin
                    s1 = CODE_SOIL;
                end
            end
            else if (is_worm(s0))
            begin
                if ({1'b0, req_reg.first_random} < death_prob_reg)
                begin
                    s1 = CODE_EMPTY;
                end
                else
                begin
                    // the worm moves into the neighbour
                    n1 = s0;
                    s1 = CODE_EMPTY;
                    if (edible)
                    begin
                        if ({1'b0, req_reg.second_random} < birth_prob_reg)
                        begin
                            s1 = s0;
                        end
                    end
                    else if (n0 == CODE_SOIL)
                    begin
                        if ({1'b0, req_reg.second_random} < deposit_prob_reg)
                        begin
                            s1 = spc;
                        end
                    end
                    else if (is_worm(n0))
                    begin
                        s1 = n0;
                    end
                end
            end
        end
        res_next.site_before = s0;
        res_next.site_after  = s1;
        res_next.neighbour_before = nbr_used_reg ? n0 : CODE_EMPTY;
        res_next.neighbour_after  = nbr_used_reg ? n1 : CODE_EMPTY;
    end

    // sequencer: next state, memory writes, output register
    always_comb
    begin
        state_next     = state_reg;
        mem_we         = 1'b0;
        mem_waddr      = site_addr_reg;
        mem_wdata      = res_reg.site_after;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // neighbour write back
                mem_we     = nbr_used_reg;
                mem_waddr  = nbr_addr_reg;
                mem_wdata  = res_next.neighbour_after;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // site write back, repeated harmlessly while the output waits
                mem_we = 1'b1;
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EVAL))
        else $error("accepted request did not enter evaluation");

    a_eval_writes_nbr: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EVAL) && mem_we) |-> (mem_waddr == nbr_addr_reg))
        else $error("evaluation write not at neighbour address");

    a_load_no_nbr: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EVAL) && (req_reg.operation == OP_LOAD)) |-> !mem_we)
        else $error("load request wrote the neighbour cell");

    a_site_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (mem_we && (mem_waddr == site_addr_reg)))
        else $error("site write missing in final cycle");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WRITE) && (state_next == ST_IDLE)) |=> out_valid)
        else $error("finished request gave no result");

endmodule

// ===== tb/lattice_worm_soil_monte_carlo_step_core_test.sv =====
`timescale 1ns / 100ps

module lattice_worm_soil_monte_carlo_step_core_test;
    import lwsmc_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 250;
    localparam int          PHASES      = 8;
    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(65536);
    localparam logic [CODE_W-1:0] CODE_UNUSED_TOP = '1;

    // neighbour direction codes
    localparam logic [2:0] DIR_X_MINUS = 3'd0;
    localparam logic [2:0] DIR_X_PLUS  = 3'd1;
    localparam logic [2:0] DIR_Y_MINUS = 3'd2;
    localparam logic [2:0] DIR_Y_PLUS  = 3'd3;
    localparam logic [2:0] DIR_Z_PLUS  = 3'd5;
    localparam logic [2:0] DIR_TOP     = 3'd7;

    // lattice predictor and queue of awaited results
    class step_scoreboard;
        logic [CODE_W-1:0] cells [CELLS];
        bit                written [CELLS];
        logic              mode;
        logic [PROB_W-1:0] fill_p;
        logic [PROB_W-1:0] death_p;
        logic [PROB_W-1:0] birth_p;
        logic [PROB_W-1:0] deposit_p;
        step_res_t         awaited [$];
        bit                fresh [$];
        int                errors;
        int                results_seen;

        function new();
            foreach (cells[i])
            begin
                cells[i]   = CODE_EMPTY;
                written[i] = 1'b0;
            end
            mode         = 1'b0;
            fill_p       = FILL_PROB_RST;
            death_p      = DEATH_PROB_RST;
            birth_p      = BIRTH_PROB_RST;
            deposit_p    = DEPOSIT_PROB_RST;
            errors       = 0;
            results_seen = 0;
        endfunction

        static function int unsigned cell_index(input int x, input int y, input int z);
            return (x * SIDE + y) * SIDE + z;
        endfunction

        // periodic neighbour along the axis named by the direction
        static function void neighbour_of(input int x, input int y, input int z,
                                          input logic [2:0] dir,
                                          output int nx, output int ny, output int nz);
            int delta;
            delta = dir[0] ? 1 : SIDE - 1;
            nx = x;
            ny = y;
            nz = z;
            case (dir >> 1)
                0: nx = (x + delta) % SIDE;
                1: ny = (y + delta) % SIDE;
                2: nz = (z + delta) % SIDE;
                default: ;
            endcase
        endfunction

        function bit holds_food(input logic [CODE_W-1:0] v);
            return v >= CODE_NUT_FIRST && v <= CODE_NUT_LAST;
        endfunction

        function bit holds_worm(input logic [CODE_W-1:0] v);
            return v >= CODE_WORM_FIRST && v <= CODE_WORM_LAST;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [PROB_W-1:0] data);
            case (idx)
                REG_RULE_MODE:    mode = data[0];
                REG_FILL_PROB:    fill_p = data;
                REG_DEATH_PROB:   death_p = data;
                REG_BIRTH_PROB:   birth_p = data;
                REG_DEPOSIT_PROB: deposit_p = data;
                default: ;
            endcase
        endfunction

        // apply one accepted request to the lattice and queue its result
        function void note_request(input step_req_t req);
            int                x, y, z, nx, ny, nz;
            int unsigned       si, ni;
            logic [CODE_W-1:0] s0, s1, n0, n1, own_food, prey;
            logic [PROB_W-1:0] r1, r2;
            bit                edible;
            bit                fresh_load;
            step_res_t         res;
            x  = int'(req.site_x) % SIDE;
            y  = int'(req.site_y) % SIDE;
            z  = int'(req.site_z) % SIDE;
            r1 = PROB_W'(req.first_random);
            r2 = PROB_W'(req.second_random);
            si = cell_index(x, y, z);
            s0 = cells[si];
            s1 = s0;
            n0 = CODE_EMPTY;
            n1 = CODE_EMPTY;
            // first load of a cell has no defined previous code
            fresh_load = (req.operation == OP_LOAD) && !written[si];
            if (req.operation == OP_LOAD)
            begin
                s1 = req.load_value;
                cells[si]   = s1;
                written[si] = 1'b1;
            end
            else if (req.direction < DIR_LIMIT)
            begin
                neighbour_of(x, y, z, req.direction, nx, ny, nz);
                ni = cell_index(nx, ny, nz);
                n0 = cells[ni];
                n1 = n0;
                if (s0 == CODE_EMPTY || holds_food(s0))
                begin
                    // soil spreads into empty or nutrient sites
                    if (n0 == CODE_SOIL && r1 < fill_p)
                    begin
                        s1 = CODE_SOIL;
                    end
                end
                else if (holds_worm(s0))
                begin
                    if (r1 < death_p)
                    begin
                        s1 = CODE_EMPTY;
                    end
                    else
                    begin
                        // worm moves, then the old neighbour code decides the rest
                        own_food = s0 - CODE_WORM_FIRST + CODE_NUT_FIRST;
                        prey     = (own_food == CODE_NUT_LAST) ? CODE_NUT_FIRST
                                                               : own_food + CODE_W'(1);
                        if (mode == 1'b0)
                        begin
                            edible = n0 == prey;
                        end
                        else
                        begin
                            edible = holds_food(n0) && n0 != own_food;
                        end
                        n1 = s0;
                        s1 = CODE_EMPTY;
                        if (edible)
                        begin
                            if (r2 < birth_p)
                            begin
                                s1 = s0;
                            end
                        end
                        else if (n0 == CODE_SOIL)
                        begin
                            if (r2 < deposit_p)
                            begin
                                s1 = own_food;
                            end
                        end
                        else if (holds_worm(n0))
                        begin
                            s1 = n0;
                        end
                    end
                end
                cells[ni] = n1;
                cells[si] = s1;
            end
            res.site_before      = s0;
            res.site_after       = s1;
            res.neighbour_before = n0;
            res.neighbour_after  = n1;
            awaited.push_back(res);
            fresh.push_back(fresh_load);
        endfunction

        // compare one accepted result with the oldest awaited one
        function void check_result(input step_res_t got);
            step_res_t want;
            bit        skip_before;
            results_seen++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("result %0d arrived with nothing awaited: site %0d->%0d nb %0d->%0d",
                             results_seen, got.site_before, got.site_after,
                             got.neighbour_before, got.neighbour_after);
                end
                return;
            end
            want        = awaited.pop_front();
            skip_before = fresh.pop_front();
            if ((!skip_before && got.site_before !== want.site_before) ||
                got.site_after !== want.site_after ||
                got.neighbour_before !== want.neighbour_before ||
                got.neighbour_after !== want.neighbour_after)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("result %0d: site %0d->%0d nb %0d->%0d, want %0d->%0d nb %0d->%0d",
                             results_seen, got.site_before, got.site_after,
                             got.neighbour_before, got.neighbour_after,
                             want.site_before, want.site_after,
                             want.neighbour_before, want.neighbour_after);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    step_req_t            in_data;
    logic                 out_valid;
    logic                 out_stall;
    step_res_t            out_data;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PROB_W-1:0]    cfg_data;

    step_scoreboard    sb;
    bit                loaded [CELLS];
    bit                sender_gaps   = 1'b1;
    bit                receiver_gaps = 1'b1;
    bit                hold_output   = 1'b0;
    int                sent          = 0;
    int                loads_sent    = 0;
    int                settings_used = 0;
    int                cycle_count   = 0;
    logic [PROB_W-1:0] cur_fill;
    logic [PROB_W-1:0] cur_death;
    logic [PROB_W-1:0] cur_birth;
    logic [PROB_W-1:0] cur_deposit;

    lattice_worm_soil_monte_carlo_step_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("no completion after %0d cycles", CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // observe register writes, accepted requests and accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                sb.set_register(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                sb.note_request(in_data);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(out_data);
            end
        end
    end

    // result side: random stall bursts and one long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_output = 1'b0;
            end
            else if (receiver_gaps && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // offer one request and wait until it is taken; returns at a falling edge
    task automatic send_request(input logic op, input int x, input int y, input int z,
                                input logic [2:0] dir, input logic [RAND_W-1:0] r1,
                                input logic [RAND_W-1:0] r2, input logic [CODE_W-1:0] code);
        step_req_t req;
        req.operation     = op;
        req.site_x        = 5'(x);
        req.site_y        = 5'(y);
        req.site_z        = 5'(z);
        req.direction     = dir;
        req.first_random  = r1;
        req.second_random = r2;
        req.load_value    = code;
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        sent++;
        if (op == OP_LOAD)
        begin
            loads_sent++;
        end
    endtask

    task automatic load_cell(input int x, input int y, input int z,
                             input logic [CODE_W-1:0] code);
        send_request(OP_LOAD, x, y, z, 3'($urandom), RAND_W'($urandom), RAND_W'($urandom), code);
        loaded[step_scoreboard::cell_index(x, y, z)] = 1'b1;
    endtask

    function automatic logic [CODE_W-1:0] pick_code();
        int w;
        w = $urandom_range(0, 99);
        if (w < 12)
        begin
            return CODE_EMPTY;
        end
        else if (w < 37)
        begin
            return CODE_NUT_FIRST + CODE_W'($urandom_range(0, SPECIES - 1));
        end
        else if (w < 60)
        begin
            return CODE_SOIL;
        end
        else if (w < 94)
        begin
            return CODE_WORM_FIRST + CODE_W'($urandom_range(0, SPECIES - 1));
        end
        return CODE_W'($urandom_range(0, 15));
    endfunction

    // a step only ever reads cells that hold a loaded code
    task automatic step_cell(input int x, input int y, input int z, input logic [2:0] dir,
                             input logic [RAND_W-1:0] r1, input logic [RAND_W-1:0] r2);
        int nx, ny, nz;
        if (!loaded[step_scoreboard::cell_index(x, y, z)])
        begin
            load_cell(x, y, z, pick_code());
        end
        if (dir < DIR_LIMIT)
        begin
            step_scoreboard::neighbour_of(x, y, z, dir, nx, ny, nz);
            if (!loaded[step_scoreboard::cell_index(nx, ny, nz)])
            begin
                load_cell(nx, ny, nz, pick_code());
            end
        end
        send_request(OP_STEP, x, y, z, dir, r1, r2, CODE_W'($urandom));
    endtask

    // let every awaited result come back with the request input idle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_settings(input logic mode, input logic [PROB_W-1:0] fill,
                                  input logic [PROB_W-1:0] death,
                                  input logic [PROB_W-1:0] birth,
                                  input logic [PROB_W-1:0] deposit);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [PROB_W-1:0]    val [5];
        idx = '{REG_RULE_MODE, REG_FILL_PROB, REG_DEATH_PROB, REG_BIRTH_PROB, REG_DEPOSIT_PROB};
        val = '{PROB_W'(mode), fill, death, birth, deposit};
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(negedge clk);
        end
        cfg_write   <= 1'b0;
        cur_fill    = fill;
        cur_death   = death;
        cur_birth   = birth;
        cur_deposit = deposit;
        settings_used++;
    endtask

    function automatic logic [PROB_W-1:0] pick_probability();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return PROB_ONE;
            2: return PROB_W'($urandom_range(1, 65535));
            3: return PROB_W'($urandom_range(0, 4096));
            default: return PROB_W'($urandom_range(49152, 65536));
        endcase
    endfunction

    // random fraction, often right at the threshold
    function automatic logic [RAND_W-1:0] pick_fraction(input logic [PROB_W-1:0] p);
        case ($urandom_range(0, 5))
            0: return (p == '0) ? RAND_W'($urandom) : RAND_W'(p - PROB_W'(1));
            1: return (p > PROB_W'(65535)) ? '1 : RAND_W'(p);
            2: return '0;
            3: return '1;
            default: return RAND_W'($urandom);
        endcase
    endfunction

    // hand-picked requests around the lattice wrap
    task automatic run_directed();
        load_cell(0, 0, 0, CODE_EMPTY);
        load_cell(31, 0, 0, CODE_SOIL);
        // fill threshold, just missed and just met
        step_cell(0, 0, 0, DIR_X_MINUS, RAND_W'(FILL_PROB_RST), '0);
        step_cell(0, 0, 0, DIR_X_MINUS, RAND_W'(FILL_PROB_RST - PROB_W'(1)), '0);
        // nutrient site filled with soil
        load_cell(0, 0, 0, CODE_NUT_LAST);
        step_cell(0, 0, 0, DIR_X_MINUS, '0, '1);
        // soil site and unused-code site stay put
        load_cell(1, 0, 0, CODE_UNUSED_TOP);
        step_cell(0, 0, 0, DIR_X_PLUS, '0, '0);
        step_cell(1, 0, 0, DIR_X_MINUS, '0, '0);
        // worm moves into soil and leaves its nutrient
        load_cell(0, 0, 31, CODE_WORM_FIRST);
        step_cell(0, 0, 31, DIR_Z_PLUS, '1, '0);
        // worm dies
        load_cell(31, 31, 31, CODE_WORM_LAST);
        load_cell(31, 31, 0, CODE_NUT_FIRST + CODE_W'(1));
        step_cell(31, 31, 31, DIR_Z_PLUS, '0, '0);
        // worm eats its prey and reproduces, death threshold just missed
        load_cell(31, 31, 31, CODE_WORM_FIRST);
        step_cell(31, 31, 31, DIR_Z_PLUS, RAND_W'(DEATH_PROB_RST), '1);
        // two worms swap
        load_cell(31, 30, 31, CODE_WORM_FIRST + CODE_W'(1));
        step_cell(31, 31, 31, DIR_Y_MINUS, '1, '1);
        // worm overwrites an unused code, then moves into empty
        load_cell(30, 31, 31, CODE_UNUSED_TOP);
        step_cell(31, 31, 31, DIR_X_MINUS, '1, '0);
        step_cell(30, 31, 31, DIR_X_PLUS, '1, '0);
        // directions past the last axis, then a step across the y wrap
        step_cell(0, 0, 0, DIR_LIMIT, '1, '1);
        step_cell(0, 0, 0, DIR_TOP, '0, '0);
        step_cell(31, 31, 0, DIR_Y_PLUS, '1, '0);
    endtask

    // random boxes of loaded cells, stepped many times each
    task automatic run_boxes(input int quota);
        int done_at, bx, by, bz, span, x, y, z;
        logic [2:0] dir;
        done_at = sent + quota;
        while (sent < done_at)
        begin
            bx   = $urandom_range(0, SIDE - 1);
            by   = $urandom_range(0, SIDE - 1);
            bz   = $urandom_range(0, SIDE - 1);
            span = $urandom_range(2, 4);
            for (int i = 0; i < span; i++)
            begin
                for (int j = 0; j < span; j++)
                begin
                    for (int k = 0; k < span; k++)
                    begin
                        x = (bx + i) % SIDE;
                        y = (by + j) % SIDE;
                        z = (bz + k) % SIDE;
                        if (!loaded[step_scoreboard::cell_index(x, y, z)] ||
                            $urandom_range(0, 2) == 0)
                        begin
                            load_cell(x, y, z, pick_code());
                        end
                    end
                end
            end
            repeat ($urandom_range(40, 100))
            begin
                if (sent >= done_at)
                begin
                    break;
                end
                x   = (bx + $urandom_range(0, span - 1)) % SIDE;
                y   = (by + $urandom_range(0, span - 1)) % SIDE;
                z   = (bz + $urandom_range(0, span - 1)) % SIDE;
                dir = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
                if ($urandom_range(0, 9) == 0)
                begin
                    load_cell(x, y, z, pick_code());
                end
                else
                begin
                    step_cell(x, y, z, dir,
                              pick_fraction($urandom_range(0, 1) ? cur_fill : cur_death),
                              pick_fraction($urandom_range(0, 1) ? cur_birth : cur_deposit));
                end
            end
        end
    endtask

    // main sequence
    initial
    begin
        sb          = new();
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_write   = 1'b0;
        cfg_index   = REG_RULE_MODE;
        cfg_data    = '0;
        rst_n       = 1'b0;
        cur_fill    = FILL_PROB_RST;
        cur_death   = DEATH_PROB_RST;
        cur_birth   = BIRTH_PROB_RST;
        cur_deposit = DEPOSIT_PROB_RST;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0: apply_settings(1'b1, '0, '0, '0, '0);
                1: apply_settings(1'b0, PROB_ONE, PROB_ONE, PROB_ONE, PROB_ONE);
                2: apply_settings(1'b0, PROB_ONE, '0, PROB_ONE, '0);
                default: apply_settings(1'($urandom_range(0, 1)), pick_probability(),
                                        ($urandom_range(0, 2) == 0) ? pick_probability()
                                            : PROB_W'($urandom_range(0, 8192)),
                                        pick_probability(), pick_probability());
            endcase
            // block fills up behind a long output hold-off
            if (ph == 4)
            begin
                hold_output = 1'b1;
            end
            // last phase runs at full rate
            if (ph == PHASES - 1)
            begin
                sender_gaps   = 1'b0;
                receiver_gaps = 1'b0;
            end
            run_boxes(ph < 2 ? 120 : 260);
        end
        drain();

        $display("%0d requests (%0d loads, %0d steps) under %0d register settings, %0d cycles",
                 sent, loads_sent, sent - loads_sent, settings_used, cycle_count);
        $display("%0d results checked, %0d mismatches, %0d results missing",
                 sb.results_seen, sb.errors, sb.awaited.size());
        if (sb.errors == 0 && sb.awaited.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lwsmc_pkg.sv
design/lattice_worm_soil_monte_carlo_step_core.sv
tb/lattice_worm_soil_monte_carlo_step_core_test.sv
